// File: hdl/ctt_pkg.sv
package ctt_pkg;

   localparam int unsigned TableDepthDefault = 64;
   localparam logic [31:0] IdleTimeoutReset = 32'd60;

   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam int unsigned FlagSyn = 1;
   localparam int unsigned FlagRst = 2;
   localparam int unsigned FlagAck = 4;

   localparam logic [1:0] KindPacket = 2'd0;
   localparam logic [1:0] KindExpire = 2'd1;
   localparam logic [1:0] KindLookup = 2'd2;

   localparam logic [1:0] VerdictNew = 2'd0;
   localparam logic [1:0] VerdictEst = 2'd1;
   localparam logic [1:0] VerdictInvalid = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  flag_bits;
      logic [15:0] length;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        found;
      logic        entry_state;
      logic [31:0] packet_total;
      logic [47:0] byte_total;
      logic [31:0] seen_time;
      logic [6:0]  expired_count;
      logic [6:0]  active_count;
   } rsp_type;

endpackage

// File: hdl/ctt_front.sv
// Accepts items into a two-entry queue and hands them to the engine.
module ctt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ctt_pkg::req_type  req_item,
   output logic              q_valid,
   output ctt_pkg::req_type  q_item,
   input  logic              q_pop
);

   ctt_pkg::req_type slot_ff [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   assign busy    = cnt_ff[1];
   assign push    = start && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item  = slot_ff[rd_ff];

   always_comb begin
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= req_item;
      end
   end

endmodule

// File: hdl/ctt_engine.sv
// Scans the table one entry a cycle, then applies the item's effect.
module ctt_engine #(
   parameter int unsigned TableDepth = ctt_pkg::TableDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       idle_timeout,
   input  logic              q_valid,
   input  ctt_pkg::req_type  q_item,
   output logic              q_pop,
   output logic              rsp_strobe,
   output ctt_pkg::rsp_type  rsp_item
);

   localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int unsigned CntW = $clog2(TableDepth + 1);
   localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(TableDepth - 1);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRead = 3'd1;
   localparam logic [2:0] StScan = 3'd2;
   localparam logic [2:0] StFetch = 3'd3;
   localparam logic [2:0] StWait = 3'd4;
   localparam logic [2:0] StApply = 3'd5;

   // entry memories
   logic [63:0] mem_addr [TableDepth];
   logic [31:0] mem_port [TableDepth];
   logic [7:0]  mem_proto [TableDepth];
   logic [31:0] mem_seen [TableDepth];
   logic [31:0] mem_pkts [TableDepth];
   logic [47:0] mem_bytes [TableDepth];
   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [TableDepth-1:0] est_ff, est_in;

   logic [63:0] rd_addr;
   logic [31:0] rd_port, rd_seen, rd_pkts;
   logic [7:0]  rd_proto;
   logic [47:0] rd_bytes;

   logic [2:0]      state_ff, state_in;
   logic [IdxW:0]   idx_ff, idx_in;
   logic [IdxW-1:0] rd_idx;
   logic [IdxW-1:0] chk_ff;
   logic            chk_live_ff;
   logic            hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic            free_ok_ff, free_ok_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic [CntW-1:0] live_ff, live_in;
   logic [CntW-1:0] freed_ff, freed_in;
   ctt_pkg::req_type item_ff;
   logic            strobe_ff, strobe_in;
   ctt_pkg::rsp_type rsp_ff, rsp_in;
   logic            we;
   logic [IdxW-1:0] wa;
   logic [63:0]     wd_addr;
   logic [31:0]     wd_port, wd_seen, wd_pkts;
   logic [7:0]      wd_proto;
   logic [47:0]     wd_bytes;

   logic            is_tcp, fwd, rev, match, idle;
   logic [IdxW-1:0] chk;
   logic [31:0]     age;

   assign q_pop      = (state_ff == StIdle) && q_valid;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign is_tcp     = item_ff.protocol == ctt_pkg::ProtoTcp;
   assign chk        = chk_ff;
   // hold the read on the matched entry until it is applied
   assign rd_idx     = (state_ff == StFetch || state_ff == StWait) ? hit_idx_ff
                                                                  : idx_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      rd_addr  <= mem_addr[rd_idx];
      rd_port  <= mem_port[rd_idx];
      rd_proto <= mem_proto[rd_idx];
      rd_seen  <= mem_seen[rd_idx];
      rd_pkts  <= mem_pkts[rd_idx];
      rd_bytes <= mem_bytes[rd_idx];
      if (we) begin
         mem_addr[wa]  <= wd_addr;
         mem_port[wa]  <= wd_port;
         mem_proto[wa] <= wd_proto;
         mem_seen[wa]  <= wd_seen;
         mem_pkts[wa]  <= wd_pkts;
         mem_bytes[wa] <= wd_bytes;
      end
   end

   always_comb begin
      fwd   = rd_addr == {item_ff.src_ip, item_ff.dst_ip}
              && rd_port == {item_ff.sport, item_ff.dport};
      rev   = rd_addr == {item_ff.dst_ip, item_ff.src_ip}
              && rd_port == {item_ff.dport, item_ff.sport};
      match = valid_ff[chk] && rd_proto == item_ff.protocol && (fwd || rev);
      age   = item_ff.now - rd_seen;
      idle  = valid_ff[chk] && age >= idle_timeout;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      live_in     = live_ff;
      freed_in    = freed_ff;
      valid_in    = valid_ff;
      est_in      = est_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      we          = 1'b0;
      wa          = hit_idx_ff;
      wd_addr     = rd_addr;
      wd_port     = rd_port;
      wd_proto    = rd_proto;
      wd_seen     = item_ff.now;
      wd_pkts     = rd_pkts + 32'd1;
      wd_bytes    = rd_bytes + {32'd0, item_ff.length};
      case (state_ff)
         StIdle: begin
            if (q_valid) begin
               idx_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               freed_in   = '0;
               state_in   = StRead;
            end
         end
         StRead: begin
            idx_in   = idx_ff + 1'b1;
            state_in = StScan;
         end
         StScan: begin
            // drop out at the first match; note the lowest free slot
            if (chk_live_ff) begin
               if (!valid_ff[chk] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = chk;
               end
               if (item_ff.kind == ctt_pkg::KindExpire) begin
                  if (idle) begin
                     valid_in[chk] = 1'b0;
                     live_in       = live_ff - 1'b1;
                     freed_in      = freed_ff + 1'b1;
                  end
               end else if (match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk;
               end
            end
            if (idx_ff > LastIdx || (hit_in && !hit_ff)) begin
               state_in = hit_in ? StFetch : StApply;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         StFetch: begin
            state_in = StWait;
         end
         StWait: begin
            state_in = StApply;
         end
         StApply: begin
            state_in  = StIdle;
            strobe_in = 1'b1;
            rsp_in    = '0;
            case (item_ff.kind)
               ctt_pkg::KindPacket: begin
                  if (hit_ff) begin
                     we = 1'b1;
                     rsp_in.verdict = est_ff[hit_idx_ff] ? ctt_pkg::VerdictEst
                                                         : ctt_pkg::VerdictNew;
                     if (is_tcp) begin
                        if (item_ff.flag_bits[ctt_pkg::FlagRst]) begin
                           valid_in[hit_idx_ff] = 1'b0;
                           live_in = live_ff - 1'b1;
                           rsp_in.verdict = ctt_pkg::VerdictInvalid;
                        end else if (est_ff[hit_idx_ff]
                                     && item_ff.flag_bits[ctt_pkg::FlagSyn]
                                     && !item_ff.flag_bits[ctt_pkg::FlagAck]) begin
                           rsp_in.verdict = ctt_pkg::VerdictInvalid;
                        end else if (!est_ff[hit_idx_ff]
                                     && item_ff.flag_bits[ctt_pkg::FlagAck]) begin
                           est_in[hit_idx_ff] = 1'b1;
                           rsp_in.verdict = ctt_pkg::VerdictEst;
                        end
                     end else if (!est_ff[hit_idx_ff]
                                  && item_ff.src_ip == rd_addr[31:0]
                                  && item_ff.dst_ip == rd_addr[63:32]) begin
                        est_in[hit_idx_ff] = 1'b1;
                        rsp_in.verdict = ctt_pkg::VerdictEst;
                     end
                  end else if ((is_tcp && (!item_ff.flag_bits[ctt_pkg::FlagSyn]
                               || item_ff.flag_bits[ctt_pkg::FlagAck]))
                               || !free_ok_ff) begin
                     rsp_in.verdict = ctt_pkg::VerdictInvalid;
                  end else begin
                     we       = 1'b1;
                     wa       = free_idx_ff;
                     wd_addr  = {item_ff.src_ip, item_ff.dst_ip};
                     wd_port  = {item_ff.sport, item_ff.dport};
                     wd_proto = item_ff.protocol;
                     wd_pkts  = 32'd1;
                     wd_bytes = {32'd0, item_ff.length};
                     valid_in[free_idx_ff] = 1'b1;
                     est_in[free_idx_ff]   = 1'b0;
                     live_in = live_ff + 1'b1;
                     rsp_in.verdict = ctt_pkg::VerdictNew;
                  end
               end
               ctt_pkg::KindExpire: begin
                  rsp_in.expired_count = 7'(freed_ff);
               end
               ctt_pkg::KindLookup: begin
                  if (hit_ff) begin
                     rsp_in.found        = 1'b1;
                     rsp_in.entry_state  = est_ff[hit_idx_ff];
                     rsp_in.packet_total = rd_pkts;
                     rsp_in.byte_total   = rd_bytes;
                     rsp_in.seen_time    = rd_seen;
                  end
               end
               default: begin
               end
            endcase
            rsp_in.active_count = 7'(live_in);
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         valid_ff  <= '0;
         live_ff   <= '0;
         strobe_ff <= 1'b0;
         hit_ff    <= 1'b0;
         free_ok_ff <= 1'b0;
         chk_live_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         live_ff   <= live_in;
         strobe_ff <= strobe_in;
         hit_ff    <= hit_in;
         free_ok_ff <= free_ok_in;
         chk_live_ff <= (state_in == StScan) && !(state_ff == StScan
                        && idx_ff > LastIdx);
      end
      idx_ff      <= idx_in;
      chk_ff      <= rd_idx;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      freed_ff    <= freed_in;
      est_ff      <= est_in;
      rsp_ff      <= rsp_in;
      if (q_pop) begin
         item_ff <= q_item;
      end
   end

endmodule

// File: hdl/connection_tracking_table.sv
// Connection tracking table over the 5-tuple, matched in either direction.
// Request channel: drive req_item and raise start; the item is taken at an
// edge where start is high and busy is low. Two items can wait in the
// input queue while the engine works.
// Result channel: rsp_strobe is high for one cycle with rsp_item; the
// receiver cannot stall it and must take it in that cycle.
// CSR channel: csr_valid/csr_ready write idle_timeout; csr_ready is always
// high. Write only while no item is in flight.
// Scan: the engine reads entries one per cycle, stopping at the first
// match for packets and lookups; expires and misses scan the full table.
// A match passes through the fetch and wait states before apply. The
// engine holds one item at a time and takes no new item until it is back
// in idle; busy rises once two items wait behind it.
// Reset: synchronous; clears all valid bits, the live count and the queue,
// and sets idle_timeout to 60. No clearing pass is needed.
module connection_tracking_table #(
   parameter int unsigned TableDepth = ctt_pkg::TableDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ctt_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output ctt_pkg::rsp_type  rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   logic [31:0]      timeout_ff;
   logic             q_valid, q_pop;
   ctt_pkg::req_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ctt_pkg::IdleTimeoutReset;
      end else if (csr_valid) begin
         timeout_ff <= csr_data;
      end
   end

   ctt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ctt_engine #(.TableDepth(TableDepth)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .idle_timeout (timeout_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

endmodule
